// ===== src/gcs_pkg.sv =====
// shared types and constants for the grouped centroid stream core
// no dependencies; imported by every module of the block
package gcs_pkg;

  // fixed field widths of the stream
  localparam int RES_W = 16;
  localparam int POS_W = 32;
  localparam int GRP_W = 16;

  // parameter defaults
  localparam int MAX_ATOMS_DEF = 256;
  localparam int COORD_W_DEF   = 32;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FIN,
    S_DIV,
    S_OUT
  } state_t;

  // per-lane command for one cycle
  typedef struct packed {
    logic open;   // load the sum with this coordinate
    logic add;    // add this coordinate to the sum
    logic start;  // snapshot sum and divisor, begin division
  } lane_ctrl_t;

  // side information of one centroid result
  typedef struct packed {
    logic [RES_W-1:0] residue;
    logic [GRP_W-1:0] group;
    logic             too_many;
    logic             is_final;
  } meta_t;

endpackage

// ===== src/gcs_lane.sv =====
// one coordinate lane: exact running sum and a bit-serial signed divider
// depends on gcs_pkg
module gcs_lane #(
  parameter int COORD_WIDTH = gcs_pkg::COORD_W_DEF,
  parameter int SUM_W       = 40,
  parameter int CNT_W       = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gcs_pkg::lane_ctrl_t     ctrl,
  input  logic [gcs_pkg::POS_W-1:0] pos,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic [gcs_pkg::POS_W-1:0] mean
);
  import gcs_pkg::*;

  localparam int CW_EFF = (COORD_WIDTH > POS_W) ? POS_W : COORD_WIDTH;
  localparam int IT_W   = $clog2(SUM_W + 1);

  logic signed [CW_EFF-1:0] coord;
  logic signed [SUM_W-1:0]  coord_ext;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         dvd;
  logic [SUM_W-1:0]         quo;
  logic [SUM_W-1:0]         quo_signed;
  logic [CNT_W-1:0]         rem;
  logic [CNT_W-1:0]         div;
  logic [CNT_W:0]           rem_sh;
  logic [CNT_W:0]           rem_sub;
  logic                     ge;
  logic                     neg;
  logic                     busy;
  logic [IT_W-1:0]          iter;

  // sign extension from the low coordinate bits
  assign coord     = pos[CW_EFF-1:0];
  assign coord_ext = SUM_W'(coord);

  // magnitude of the sum for the unsigned divider
  assign sum_mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

  // one restoring step
  assign rem_sh  = {rem, dvd[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div};
  assign rem_sub = rem_sh - {1'b0, div};

  // running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.open) begin
      sum <= coord_ext;
    end else if (ctrl.add) begin
      sum <= sum + coord_ext;
    end
  end

  // divider control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= IT_W'(SUM_W);
    end else if (busy) begin
      iter <= iter - IT_W'(1);
      if (iter == IT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // divider datapath, snapshot taken at start
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= sum_mag;
      neg <= sum[SUM_W-1];
      div <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // restore sign, truncation toward zero
  assign quo_signed = neg ? (~quo + SUM_W'(1)) : quo;
  assign mean       = (div == '0) ? '0 : quo_signed[POS_W-1:0];

endmodule

// ===== src/gcs_merge.sv =====
// merging stage: joins the three lane quotients with their side data
// into the registered output stream; depends on gcs_pkg
module gcs_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  gcs_pkg::meta_t            meta,
  input  logic [gcs_pkg::POS_W-1:0] mean_x,
  input  logic [gcs_pkg::POS_W-1:0] mean_y,
  input  logic [gcs_pkg::POS_W-1:0] mean_z,
  output logic                      free,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // residue_out[15:0], mean_x[47:16], mean_y[79:48], mean_z[111:80],
  // group_number[127:112]
  output logic [127:0]              m_axis_tdata,
  // too_many[0]
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);
  import gcs_pkg::*;

  // output register is free when empty or emptying this cycle
  assign free = !m_axis_tvalid || m_axis_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {meta.group, mean_z, mean_y, mean_x, meta.residue};
      m_axis_tuser <= meta.too_many;
      m_axis_tlast <= meta.is_final;
    end
  end

endmodule

// ===== src/grouped_centroid_stream_core.sv =====
// grouped centroid stream core: three coordinate lanes, each with an exact sum and its own
// bit-serial divider, a group sequencer and an output merge. An atom that closes a group
// starts its SUM_W-bit division (SUM_W = 32 + clog2 of the atom capacity, 40 by default);
// the result is loaded once all lanes are done. A last atom flushes its own group via the
// snapshot state after any group it closed. Throughput: one atom per cycle with no result;
// input is held until the result is loaded, plus any output stall. Reset: sync high
module grouped_centroid_stream_core #(
  parameter int MAX_RESIDUE_ATOMS = gcs_pkg::MAX_ATOMS_DEF,
  parameter int COORD_WIDTH       = gcs_pkg::COORD_W_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // residue[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80]
  input  logic [111:0] s_axis_tdata,
  // last_atom
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // residue_out[15:0], mean_x[47:16], mean_y[79:48], mean_z[111:80],
  // group_number[127:112]
  output logic [127:0] m_axis_tdata,
  // too_many[0]
  output logic         m_axis_tuser,
  // final_result
  output logic         m_axis_tlast
);
  import gcs_pkg::*;

  localparam int SUM_W = POS_W + $clog2(MAX_RESIDUE_ATOMS);
  localparam int CNT_W = $clog2(MAX_RESIDUE_ATOMS + 1);

  state_t            state;
  state_t            state_next;
  logic [RES_W-1:0]  cur_res;
  logic [GRP_W-1:0]  group_cnt;
  logic [CNT_W-1:0]  atom_cnt;
  logic              started;
  logic              dropped;
  logic              pend_fin;
  meta_t             cur_meta;
  meta_t             fin_meta;
  meta_t             fin_meta_next;
  lane_ctrl_t        lane_ctrl;
  logic              accept;
  logic              closing;
  logic              opening;
  logic              can_add;
  logic              all_done;
  logic              merge_free;
  logic              merge_load;
  logic [RES_W-1:0]  rid;
  logic [2:0]        lane_done;
  logic [POS_W-1:0]  mean_x;
  logic [POS_W-1:0]  mean_y;
  logic [POS_W-1:0]  mean_z;

  assign rid      = s_axis_tdata[RES_W-1:0];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign closing  = started && (rid != cur_res);
  assign opening  = !started || closing;
  assign can_add  = atom_cnt < CNT_W'(MAX_RESIDUE_ATOMS);
  assign all_done = &lane_done;

  // side data of the group left open after this atom
  always_comb begin
    fin_meta_next.residue  = opening ? rid : cur_res;
    fin_meta_next.group    = closing ? (group_cnt + GRP_W'(1)) : group_cnt;
    fin_meta_next.too_many = opening ? 1'b0 : (dropped || !can_add);
    fin_meta_next.is_final = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (closing) begin
            state_next = S_DIV;
          end else if (s_axis_tlast) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (all_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (merge_free) begin
          state_next = pend_fin ? S_FIN : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    lane_ctrl.open  = 1'b0;
    lane_ctrl.add   = 1'b0;
    lane_ctrl.start = 1'b0;
    merge_load      = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready   = 1'b1;
        lane_ctrl.open  = accept && opening;
        lane_ctrl.add   = accept && !opening && can_add;
        lane_ctrl.start = accept && closing;
      end
      S_FIN: begin
        lane_ctrl.start = 1'b1;
      end
      S_OUT: begin
        merge_load = merge_free;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // group bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_res   <= '0;
      group_cnt <= '0;
      atom_cnt  <= '0;
      started   <= 1'b0;
      dropped   <= 1'b0;
      pend_fin  <= 1'b0;
    end else begin
      if (accept) begin
        if (opening) begin
          cur_res  <= rid;
          atom_cnt <= CNT_W'(1);
          dropped  <= 1'b0;
          started  <= 1'b1;
          if (closing) begin
            group_cnt <= group_cnt + GRP_W'(1);
          end
        end else if (can_add) begin
          atom_cnt <= atom_cnt + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
        if (s_axis_tlast) begin
          started   <= 1'b0;
          group_cnt <= '0;
        end
        pend_fin <= closing && s_axis_tlast;
      end else if (state == S_FIN) begin
        pend_fin <= 1'b0;
      end
    end
  end

  // side data of the division in flight and of a pending final result
  always_ff @(posedge clk) begin
    if (accept) begin
      fin_meta <= fin_meta_next;
      if (closing) begin
        cur_meta.residue  <= cur_res;
        cur_meta.group    <= group_cnt;
        cur_meta.too_many <= dropped;
        cur_meta.is_final <= 1'b0;
      end
    end else if (state == S_FIN) begin
      cur_meta <= fin_meta;
    end
  end

  // coordinate lanes
  gcs_lane #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .pos     (s_axis_tdata[RES_W +: POS_W]),
    .divisor (atom_cnt),
    .done    (lane_done[0]),
    .mean    (mean_x)
  );

  gcs_lane #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .pos     (s_axis_tdata[RES_W + POS_W +: POS_W]),
    .divisor (atom_cnt),
    .done    (lane_done[1]),
    .mean    (mean_y)
  );

  gcs_lane #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_lane_z (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .pos     (s_axis_tdata[RES_W + 2*POS_W +: POS_W]),
    .divisor (atom_cnt),
    .done    (lane_done[2]),
    .mean    (mean_z)
  );

  // output merge
  gcs_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (merge_load),
    .meta          (cur_meta),
    .mean_x        (mean_x),
    .mean_y        (mean_y),
    .mean_z        (mean_z),
    .free          (merge_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/tb_grouped_centroid_stream_core.sv =====
// self-checking testbench for grouped_centroid_stream_core: directed and random atom streams
// with bursty input and a stalling result side; depends on src/gcs_pkg.sv and the core rtl
`timescale 1ns / 100ps

module tb_grouped_centroid_stream_core;

  localparam int MAX_ATOMS   = gcs_pkg::MAX_ATOMS_DEF;
  localparam int COORD_W     = gcs_pkg::COORD_W_DEF;
  localparam int COORD_W_EFF = (COORD_W > gcs_pkg::POS_W) ? gcs_pkg::POS_W : COORD_W;
  localparam int ITEMS       = 950;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic [gcs_pkg::RES_W-1:0] residue;
    logic [gcs_pkg::POS_W-1:0] x, y, z;
    logic                      last;
  } atom_t;

  typedef struct {
    logic [gcs_pkg::RES_W-1:0] residue;
    logic [gcs_pkg::POS_W-1:0] mx, my, mz;
    logic [gcs_pkg::GRP_W-1:0] group;
    logic                      too_many;
    logic                      fin;
  } centroid_t;

  // running group state and the queue of centroids still owed by the core
  class centroid_board;
    logic [gcs_pkg::RES_W-1:0] open_residue;
    longint                    acc_x, acc_y, acc_z;
    int unsigned               n_atoms;
    logic [gcs_pkg::GRP_W-1:0] group_idx;
    bit                        in_stream;
    bit                        overflowed;
    centroid_t                 owed_means[$];
    int                        errors;

    function new();
      open_residue = '0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      n_atoms = 0;
      group_idx = '0;
      in_stream = 0;
      overflowed = 0;
      errors = 0;
    endfunction

    // sign-extend from the low coordinate bits
    function longint widen(logic [gcs_pkg::POS_W-1:0] raw);
      longint v;
      v = longint'($signed(raw));
      v = (v <<< (64 - COORD_W_EFF)) >>> (64 - COORD_W_EFF);
      return v;
    endfunction

    // exact sum over count, truncated toward zero, kept to 32 bits
    function logic [gcs_pkg::POS_W-1:0] mean_of(longint s);
      longint q;
      q = s / longint'(n_atoms);
      return q[gcs_pkg::POS_W-1:0];
    endfunction

    function void close_group(bit fin);
      centroid_t c;
      c.residue  = open_residue;
      c.mx       = mean_of(acc_x);
      c.my       = mean_of(acc_y);
      c.mz       = mean_of(acc_z);
      c.group    = group_idx;
      c.too_many = overflowed;
      c.fin      = fin;
      owed_means = {owed_means, c};
    endfunction

    function void open_group(atom_t a);
      open_residue = a.residue;
      acc_x = widen(a.x);
      acc_y = widen(a.y);
      acc_z = widen(a.z);
      n_atoms = 1;
      overflowed = 0;
      in_stream = 1;
    endfunction

    // accepted atom: update sums and queue any centroids it closes
    function void take_atom(atom_t a);
      if (!in_stream) begin
        open_group(a);
      end else if (a.residue != open_residue) begin
        close_group(0);
        group_idx = group_idx + 1'b1;
        open_group(a);
      end else if (n_atoms < MAX_ATOMS) begin
        acc_x += widen(a.x);
        acc_y += widen(a.y);
        acc_z += widen(a.z);
        n_atoms++;
      end else begin
        overflowed = 1;
      end
      if (a.last) begin
        close_group(1);
        in_stream = 0;
        group_idx = '0;
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // accepted result transaction against the oldest owed centroid
    function void match_centroid(centroid_t got);
      centroid_t want;
      if (owed_means.size() == 0) begin
        $display("%0t unexpected centroid: expected none actual residue %h group %h",
                 $time, got.residue, got.group);
        errors++;
        return;
      end
      want = owed_means.pop_front();
      compare("residue_out", 32'(want.residue), 32'(got.residue));
      compare("mean_x", want.mx, got.mx);
      compare("mean_y", want.my, got.my);
      compare("mean_z", want.mz, got.mz);
      compare("group_number", 32'(want.group), 32'(got.group));
      compare("too_many", 32'(want.too_many), 32'(got.too_many));
      compare("final_result", 32'(want.fin), 32'(got.fin));
    endfunction

    function int owed();
      return owed_means.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  centroid_board board;
  int            sent;
  int            burst_left;
  logic [15:0]   prev_residue;
  int            idle_cycles;
  int            rx_cycle;
  int            rx_mode;

  grouped_centroid_stream_core #(
    .MAX_RESIDUE_ATOMS(MAX_ATOMS),
    .COORD_WIDTH(COORD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  // sample both buses at the edge where the transaction happens
  always @(posedge clk) begin
    atom_t     a;
    centroid_t c;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        a.residue = s_axis_tdata[15:0];
        a.x       = s_axis_tdata[47:16];
        a.y       = s_axis_tdata[79:48];
        a.z       = s_axis_tdata[111:80];
        a.last    = s_axis_tlast;
        board.take_atom(a);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        c.residue  = m_axis_tdata[15:0];
        c.mx       = m_axis_tdata[47:16];
        c.my       = m_axis_tdata[79:48];
        c.mz       = m_axis_tdata[111:80];
        c.group    = m_axis_tdata[127:112];
        c.too_many = m_axis_tuser;
        c.fin      = m_axis_tlast;
        board.match_centroid(c);
      end
    end
  end

  // result side: the stall mode is redrawn at random from four ready patterns
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cycle = 0;
      rx_mode = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_cycle % 64) >= 40);
      endcase
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("[grouped_centroid_stream_core] ERROR");
        $finish;
      end
    end
  end

  // one atom, with a random gap when the current burst runs out
  task automatic send_atom(logic [15:0] res, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tdata  <= {z, y, x, res};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    prev_residue = res;
    sent++;
  endtask

  // hold off input until every owed centroid has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom;
      4, 5: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default:
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
    endcase
  endfunction

  // one residue group; long groups push the sums to the capacity edge
  task automatic send_group(logic [15:0] res, int len, bit long_run, bit close_stream);
    logic        last;
    logic [31:0] x, y, z;
    for (int i = 0; i < len; i++) begin
      if (long_run) begin
        x = 32'h7FFF_FFFF;
        y = 32'h8000_0000;
        z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (i >= MAX_ATOMS) x = pick_coord();
      end else begin
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
      end
      // an occasional stray end marker breaks the stream mid-group
      last = (close_stream && i == len - 1) || (!long_run && $urandom_range(0, 39) == 0);
      send_atom(res, x, y, z, last);
    end
  endtask

  initial begin
    int          n_groups;
    int          len;
    bit          full_done;
    bit          over_done;
    logic [15:0] res;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    sent = 0;
    burst_left = 0;
    prev_residue = '0;
    idle_cycles = 0;
    full_done = 0;
    over_done = 0;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first atom of a stream that is also its last
    send_atom(16'h0000, 32'h0, 32'h0, 32'h0, 1'b1);
    // extremes in one group; means round toward zero
    send_atom(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_atom(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_atom(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    // residue change closes the group; small sums, some negative, over three
    send_atom(16'h1234, 32'hFFFF_FFFF, 32'h0000_0005, 32'hFFFF_FFF9, 1'b0);
    send_atom(16'h1234, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0000, 1'b0);
    send_atom(16'h1234, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 1'b0);
    // residue change together with the last atom gives two centroids
    send_atom(16'h00FF, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_FFFF, 1'b1);
    // same residue again opens a fresh stream at group zero
    send_atom(16'h00FF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0);
    send_atom(16'h00FE, 32'hEDCB_A987, 32'h6543_210F, 32'hF0F0_F0F0, 1'b0);
    send_atom(16'h00FE, 32'h0000_0003, 32'hFFFF_FFFD, 32'h5555_5555, 1'b0);
    send_atom(16'h0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_atom(16'h0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();

    // random streams of random groups, with two groups at the capacity edge
    while (sent < ITEMS) begin
      n_groups = $urandom_range(1, 8);
      for (int g = 0; g < n_groups; g++) begin
        res = ($urandom_range(0, 7) == 0) ? prev_residue : 16'($urandom_range(0, 65535));
        if (!full_done && sent > 250) begin
          send_group(res, MAX_ATOMS, 1'b1, 1'b0);
          full_done = 1;
        end else if (!over_done && sent > 600) begin
          send_group(res, MAX_ATOMS + $urandom_range(1, 6), 1'b1, 1'b0);
          over_done = 1;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
          send_group(res, len, 1'b0, g == n_groups - 1 && $urandom_range(0, 7) != 0);
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    // flush whatever group is still open
    send_atom(16'($urandom_range(0, 65535)), pick_coord(), pick_coord(), pick_coord(), 1'b1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.owed() == 0) begin
      $display("[grouped_centroid_stream_core] OK");
    end else begin
      $display("[grouped_centroid_stream_core] ERROR");
    end
    $finish;
  end

endmodule
